// ===== rtl/core/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// Palette index compactor package
// Shared widths, the map entry layout and the colour depth classes.
// ----------------------------------------------------------------------------
`default_nettype none

package pic_pkg;

  // Fixed field widths of the pixel and result beats.
  localparam int CI_W    = 9;   // source colour index
  localparam int CH_W    = 8;   // one colour channel
  localparam int RGB_W   = 3 * CH_W;
  localparam int POS_W   = 9;   // position in the compacted palette
  localparam int CNT_W   = 10;  // distinct colour count
  localparam int CLASS_W = 2;

  // Frame generation number kept beside each index binding.
  localparam int EPOCH_W = 8;

  // Upper count limits of the first three depth classes.
  localparam logic [CNT_W-1:0] LIMIT_1BIT = CNT_W'(2);
  localparam logic [CNT_W-1:0] LIMIT_4BIT = CNT_W'(16);
  localparam logic [CNT_W-1:0] LIMIT_8BIT = CNT_W'(256);

  // Depth class codes.
  localparam logic [CLASS_W-1:0] DEPTH_1BIT  = 2'd0;
  localparam logic [CLASS_W-1:0] DEPTH_4BIT  = 2'd1;
  localparam logic [CLASS_W-1:0] DEPTH_8BIT  = 2'd2;
  localparam logic [CLASS_W-1:0] DEPTH_24BIT = 2'd3;

  typedef logic [RGB_W-1:0] rgb_t;

  // One binding of a source index: the frame it belongs to and its position.
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [POS_W-1:0]   pos;
  } map_entry_t;

  // Bits per pixel needed for a palette of the given size.
  function automatic logic [CLASS_W-1:0] class_of(input logic [CNT_W-1:0] cnt);
    logic [CLASS_W-1:0] cls;
    if (cnt <= LIMIT_1BIT) begin
      cls = DEPTH_1BIT;
    end else if (cnt <= LIMIT_4BIT) begin
      cls = DEPTH_4BIT;
    end else if (cnt <= LIMIT_8BIT) begin
      cls = DEPTH_8BIT;
    end else begin
      cls = DEPTH_24BIT;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pic_if.sv =====
// ----------------------------------------------------------------------------
// Palette index compactor channels
// Valid/ready channels for pixel beats and for result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface pic_pix_if
  import pic_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic            frame_start;
  logic [CI_W-1:0] color_index;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic            last_pixel;

  modport source (
    output valid, frame_start, color_index, red, green, blue, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, frame_start, color_index, red, green, blue, last_pixel,
    output ready
  );
endinterface

interface pic_res_if
  import pic_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   new_index;
  logic [CNT_W-1:0]   distinct_count;
  logic [CLASS_W-1:0] depth_class;
  logic               frame_done;

  modport source (
    output valid, new_index, distinct_count, depth_class, frame_done,
    input  ready
  );
  modport sink (
    input  valid, new_index, distinct_count, depth_class, frame_done,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/pic_sync_ram.sv =====
// ----------------------------------------------------------------------------
// Palette index compactor RAM
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pic_sync_ram
  import pic_pkg::*;
#(
  parameter int WIDTH = 17,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/pic_index_reduce.sv =====
// ----------------------------------------------------------------------------
// Palette index compactor index reduction
// Folds the source colour index into the table range in two steps.
// ----------------------------------------------------------------------------
`default_nettype none

module pic_index_reduce
  import pic_pkg::*;
#(
  parameter int INDEX_COUNT = 512
) (
  input  wire logic                           clk,
  input  wire logic                           load,
  input  wire logic [CI_W-1:0]                color_index,
  output logic      [$clog2(INDEX_COUNT)-1:0] idx
);

  localparam int IDX_W = $clog2(INDEX_COUNT);
  // A 9-bit dividend and a 22-bit fraction leave the estimated quotient exact.
  localparam int SHIFT = 22;
  localparam int RECIP = ((2 ** SHIFT) + INDEX_COUNT - 1) / INDEX_COUNT;

  logic [31:0]     prod;
  logic [31:0]     rem;
  logic [CI_W-1:0] x_r;
  logic [CI_W-1:0] q_r;

  // Quotient by multiplication with the reciprocal.
  assign prod = 32'(color_index) * 32'(RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= color_index;
      q_r <= prod[SHIFT+CI_W-1:SHIFT];
    end
  end

  // Remainder from the registered quotient.
  assign rem = 32'(x_r) - 32'(q_r) * 32'(INDEX_COUNT);
  assign idx = IDX_W'(rem);

endmodule

`default_nettype wire

// ===== rtl/core/palette_index_compactor_unit.sv =====
// ----------------------------------------------------------------------------
// Palette index compactor
// Maps source colour indices onto a compacted palette of distinct colours.
// ----------------------------------------------------------------------------
// Pixel beats arrive on in_pix and one result beat per pixel leaves on
// out_res, both valid/ready channels. Pixels are handled one at a time.
// An index already bound in the current frame passes from accept to the
// result register in these steps: accept, index reduction and map read,
// lookup, result load. An index seen for the first time also scans the
// colour list if it is not empty, one stored colour per cycle through the
// colour RAM read port, comparing at most the current count of colours.
// A new pixel is accepted as soon as the previous one has reached the
// result register, even while that result still waits; a stalled receiver
// holds the next pixel in the final step. Frame starts advance an 8-bit
// frame generation held in the map RAM. After reset, and whenever that
// generation wraps (every 255th frame start), a clearing pass writes every
// map entry, and no pixel is accepted while it runs.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_index_compactor_unit
  import pic_pkg::*;
#(
  parameter int INDEX_COUNT = 512
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pic_pix_if.sink    in_pix,
  pic_res_if.source  out_res
);

  localparam int IDX_W = $clog2(INDEX_COUNT);
  localparam int MAP_W = $bits(map_entry_t);
  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(INDEX_COUNT - 1);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(INDEX_COUNT - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MAP   = 6'b000100,
    ST_LOOK  = 6'b001000,
    ST_SRCH  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  // Control registers.
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic               resume_r, resume_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  rgb_t               rgb_r;
  logic               last_r;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   out_index_r;
  logic [CNT_W-1:0]   out_count_r;
  logic [CLASS_W-1:0] out_class_r;
  logic               out_done_r;

  // RAM ports.
  logic               map_we;
  logic [IDX_W-1:0]   map_waddr;
  map_entry_t         map_wentry;
  logic [IDX_W-1:0]   map_raddr;
  logic [MAP_W-1:0]   map_rdata;
  map_entry_t         map_rentry;
  logic               col_we;
  logic [IDX_W-1:0]   col_waddr;
  logic [IDX_W-1:0]   col_raddr;
  rgb_t               col_rdata;

  logic               in_fire;
  logic               out_load;
  logic               list_full;
  logic [CNT_W-1:0]   k_inc;
  logic [IDX_W-1:0]   red_idx;

  assign in_fire    = in_pix.valid && in_pix.ready;
  assign map_rentry = map_entry_t'(map_rdata);
  assign list_full  = 32'(count_r) >= 32'(INDEX_COUNT);
  assign k_inc      = k_r + CNT_W'(1);

  pic_index_reduce #(
    .INDEX_COUNT (INDEX_COUNT)
  ) u_reduce (
    .clk         (clk),
    .load        (in_fire),
    .color_index (in_pix.color_index),
    .idx         (red_idx)
  );

  // Index bindings with their frame generation.
  pic_sync_ram #(
    .WIDTH (MAP_W),
    .DEPTH (INDEX_COUNT)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (MAP_W'(map_wentry)),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // Distinct colour list.
  pic_sync_ram #(
    .WIDTH (RGB_W),
    .DEPTH (INDEX_COUNT)
  ) u_color_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (rgb_r),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    resume_nxt    = resume_r;
    epoch_nxt     = epoch_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    out_load      = 1'b0;
    map_we        = 1'b0;
    map_waddr     = idx_r;
    map_wentry    = '{epoch: epoch_r, pos: pos_r};
    map_raddr     = red_idx;
    col_we        = 1'b0;
    col_waddr     = IDX_W'(count_r);
    col_raddr     = IDX_W'(k_inc);
    in_pix.ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        // Mark every binding as belonging to no live frame.
        map_we      = 1'b1;
        map_waddr   = clr_cnt_r;
        map_wentry  = '{epoch: '0, pos: '0};
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == LAST_ADDR) begin
          resume_nxt = 1'b0;
          state_nxt  = resume_r ? ST_MAP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_pix.ready = 1'b1;
        if (in_pix.valid) begin
          state_nxt = ST_MAP;
          if (in_pix.frame_start) begin
            count_nxt = '0;
            if (epoch_r == '1) begin
              epoch_nxt   = EPOCH_FIRST;
              clr_cnt_nxt = '0;
              resume_nxt  = 1'b1;
              state_nxt   = ST_CLEAR;
            end else begin
              epoch_nxt = epoch_r + EPOCH_W'(1);
            end
          end
        end
      end
      ST_MAP: begin
        // The reduced index addresses the map.
        map_raddr = red_idx;
        idx_nxt   = red_idx;
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        if (map_rentry.epoch == epoch_r) begin
          pos_nxt   = map_rentry.pos;
          state_nxt = ST_OUT;
        end else if (count_r == '0) begin
          col_we     = 1'b1;
          pos_nxt    = POS_W'(count_r);
          count_nxt  = count_r + CNT_W'(1);
          map_we     = 1'b1;
          map_wentry = '{epoch: epoch_r, pos: POS_W'(count_r)};
          state_nxt  = ST_OUT;
        end else begin
          col_raddr = '0;
          k_nxt     = '0;
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        // Compare one stored colour per cycle while the next is read.
        if (col_rdata == rgb_r) begin
          pos_nxt    = POS_W'(k_r);
          map_we     = 1'b1;
          map_wentry = '{epoch: epoch_r, pos: POS_W'(k_r)};
          state_nxt  = ST_OUT;
        end else if (k_inc < count_r) begin
          k_nxt = k_inc;
        end else begin
          map_we    = 1'b1;
          state_nxt = ST_OUT;
          if (list_full) begin
            pos_nxt    = LAST_POS;
            map_wentry = '{epoch: epoch_r, pos: LAST_POS};
          end else begin
            col_we     = 1'b1;
            pos_nxt    = POS_W'(count_r);
            count_nxt  = count_r + CNT_W'(1);
            map_wentry = '{epoch: epoch_r, pos: POS_W'(count_r)};
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_res.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      resume_r    <= 1'b0;
      epoch_r     <= EPOCH_FIRST;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      resume_r    <= resume_nxt;
      epoch_r     <= epoch_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pixel payload and result beat.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    if (in_fire) begin
      rgb_r  <= {in_pix.red, in_pix.green, in_pix.blue};
      last_r <= in_pix.last_pixel;
    end
    if (out_load) begin
      out_index_r <= pos_r;
      out_count_r <= count_r;
      out_class_r <= last_r ? class_of(count_r) : DEPTH_1BIT;
      out_done_r  <= last_r;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.new_index      = out_index_r;
  assign out_res.distinct_count = out_count_r;
  assign out_res.depth_class    = out_class_r;
  assign out_res.frame_done     = out_done_r;

  // Only one pixel is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_pix.ready)
    else $error("pixel accepted while another is in flight");

  // The colour scan never compares past the end of the list.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> (k_r < count_r))
    else $error("colour scan beyond list end");

  // The list never grows beyond the table.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(INDEX_COUNT))
    else $error("colour count beyond table size");

  // The live frame generation is never the cleared mark.
  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("frame generation equals cleared mark");

  // A result for an empty result register is shown in the next cycle.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded");

endmodule

`default_nettype wire
